// File: rtl/aaci_pkg.sv
// Shared constants, types and command-name tables for the ASCII arithmetic interpreter.
package aaci_pkg;

   localparam int LINE_CAPACITY = 256;
   localparam int MAX_ARGS      = 4;
   localparam int VALUE_WIDTH   = 32;
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
   localparam int SPC_W         = $clog2(MAX_ARGS + 2);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_DIGIT = 2'd0;
   localparam logic [1:0] OP_FOLD  = 2'd1;
   localparam logic [1:0] OP_LINE  = 2'd2;
   localparam logic [1:0] OP_OVFL  = 2'd3;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_BYE = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_CMD  = 3'd1;
   localparam logic [2:0] ST_FEW_ARGS = 3'd2;
   localparam logic [2:0] ST_MANY     = 3'd3;
   localparam logic [2:0] ST_BAD_IN   = 3'd4;
   localparam logic [2:0] ST_BYE      = 3'd5;
   localparam logic [2:0] ST_OVERFLOW = 3'd6;

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] digit;
      logic       first;
      logic       fold;
      logic [1:0] cmd;
      logic [2:0] status;
   } entry_type;

   function automatic logic [3:0] cmd_len(input logic [1:0] c);
      logic [3:0] len;
      unique case (c)
         CMD_ADD: len = 4'd3;
         CMD_SUB: len = 4'd8;
         CMD_MUL: len = 4'd8;
         default: len = 4'd3;
      endcase
      return len;
   endfunction

   // character at position pos of a command name; valid only for pos < cmd_len(c)
   function automatic logic [7:0] cmd_char(input logic [1:0] c, input logic [3:0] pos);
      logic [63:0] s;
      logic [3:0]  idx;
      unique case (c)
         CMD_ADD: s = 64'("add");
         CMD_SUB: s = 64'("subtract");
         CMD_MUL: s = 64'("multiply");
         default: s = 64'("bye");
      endcase
      idx = cmd_len(c) - pos - 4'd1;
      return s[{idx[2:0], 3'b000} +: 8];
   endfunction

endpackage

// File: rtl/aaci_front.sv
// Front end: accepts bytes, tracks line syntax and the command word, queues work items.
module aaci_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte_req,
   input  logic                 q_full,
   output logic                 q_push,
   output aaci_pkg::entry_type  q_data
);

   logic                        ignoring_ff, ignoring_in;
   logic [aaci_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [3:0]                  cand_ff, cand_in;
   logic [3:0]                  pos_ff, pos_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic                        nul_ff, nul_in;
   logic [aaci_pkg::SPC_W-1:0]  spc_ff, spc_in;
   logic                        bad_ff, bad_in;
   logic                        empty_ff, empty_in;
   logic                        lastsp_ff, lastsp_in;

   logic       accept, is_nl, is_sp, is_dig, spc_zero, arg_open, ovfl;
   logic [3:0] res_cand, letter_cand;
   logic [1:0] res_code;
   logic [3:0] cand_now;
   logic [1:0] code_now;
   logic       empty_now;
   logic [2:0] status;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_nl     = req_byte_req == aaci_pkg::CH_NL;
   assign is_sp     = req_byte_req == aaci_pkg::CH_SPACE;
   assign is_dig    = req_byte_req >= aaci_pkg::CH_ZERO && req_byte_req <= aaci_pkg::CH_NINE;
   assign spc_zero  = spc_ff == '0;
   assign arg_open  = !spc_zero && spc_ff <= aaci_pkg::SPC_W'(aaci_pkg::MAX_ARGS);
   assign ovfl      = len_ff == aaci_pkg::LEN_W'(aaci_pkg::LINE_CAPACITY - 1);

   always_comb begin
      res_code = cmd_ff;
      for (int c = 0; c < 4; c++) begin
         res_cand[c]    = cand_ff[c] && (aaci_pkg::cmd_len(2'(c)) == pos_ff);
         letter_cand[c] = cand_ff[c] && (pos_ff < aaci_pkg::cmd_len(2'(c)))
                          && (aaci_pkg::cmd_char(2'(c), pos_ff) == req_byte_req);
         if (res_cand[c]) begin
            res_code = 2'(c);
         end
      end
   end

   always_comb begin
      cand_now  = spc_zero ? res_cand : cand_ff;
      code_now  = spc_zero ? res_code : cmd_ff;
      empty_now = empty_ff || (!spc_zero && lastsp_ff);
      if (nul_ff) begin
         status = aaci_pkg::ST_BAD_CMD;
      end else if (spc_ff > aaci_pkg::SPC_W'(aaci_pkg::MAX_ARGS)) begin
         status = aaci_pkg::ST_MANY;
      end else if (cand_now == '0) begin
         status = aaci_pkg::ST_BAD_CMD;
      end else if (code_now == aaci_pkg::CMD_BYE) begin
         status = aaci_pkg::ST_BYE;
      end else if (spc_ff < aaci_pkg::SPC_W'(2)) begin
         status = aaci_pkg::ST_FEW_ARGS;
      end else if (bad_ff || empty_now) begin
         status = aaci_pkg::ST_BAD_IN;
      end else begin
         status = aaci_pkg::ST_OK;
      end
   end

   always_comb begin
      ignoring_in = ignoring_ff;
      len_in      = len_ff;
      cand_in     = cand_ff;
      pos_in      = pos_ff;
      cmd_in      = cmd_ff;
      nul_in      = nul_ff;
      spc_in      = spc_ff;
      bad_in      = bad_ff;
      empty_in    = empty_ff;
      lastsp_in   = lastsp_ff;
      q_push      = 1'b0;
      q_data.op     = aaci_pkg::OP_DIGIT;
      q_data.digit  = req_byte_req[3:0];
      q_data.first  = spc_ff == aaci_pkg::SPC_W'(1);
      q_data.fold   = arg_open;
      q_data.cmd    = code_now;
      q_data.status = status;
      if (accept) begin
         if (ignoring_ff) begin
            ignoring_in = !is_nl;
         end else if (is_nl || ovfl) begin
            q_push      = 1'b1;
            q_data.op   = is_nl ? aaci_pkg::OP_LINE : aaci_pkg::OP_OVFL;
            ignoring_in = !is_nl;
            len_in      = '0;
            cand_in     = 4'hF;
            pos_in      = '0;
            cmd_in      = aaci_pkg::CMD_ADD;
            nul_in      = 1'b0;
            spc_in      = '0;
            bad_in      = 1'b0;
            empty_in    = 1'b0;
            lastsp_in   = 1'b0;
         end else begin
            len_in = len_ff + aaci_pkg::LEN_W'(1);
            if (req_byte_req == 8'd0) begin
               nul_in = 1'b1;
            end
            if (is_sp) begin
               if (spc_zero) begin
                  cand_in = res_cand;
                  cmd_in  = res_code;
               end else begin
                  if (lastsp_ff) begin
                     empty_in = 1'b1;
                  end
                  if (arg_open) begin
                     q_push    = 1'b1;
                     q_data.op = aaci_pkg::OP_FOLD;
                  end
               end
               if (spc_ff <= aaci_pkg::SPC_W'(aaci_pkg::MAX_ARGS)) begin
                  spc_in = spc_ff + aaci_pkg::SPC_W'(1);
               end
               lastsp_in = 1'b1;
            end else begin
               if (spc_zero) begin
                  cand_in = letter_cand;
                  if (pos_ff != 4'hF) begin
                     pos_in = pos_ff + 4'd1;
                  end
               end else if (is_dig) begin
                  q_push = arg_open;
               end else begin
                  bad_in = 1'b1;
               end
               lastsp_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignoring_ff <= 1'b0;
         len_ff      <= '0;
         cand_ff     <= 4'hF;
         pos_ff      <= '0;
         cmd_ff      <= aaci_pkg::CMD_ADD;
         nul_ff      <= 1'b0;
         spc_ff      <= '0;
         bad_ff      <= 1'b0;
         empty_ff    <= 1'b0;
         lastsp_ff   <= 1'b0;
      end else begin
         ignoring_ff <= ignoring_in;
         len_ff      <= len_in;
         cand_ff     <= cand_in;
         pos_ff      <= pos_in;
         cmd_ff      <= cmd_in;
         nul_ff      <= nul_in;
         spc_ff      <= spc_in;
         bad_ff      <= bad_in;
         empty_ff    <= empty_in;
         lastsp_ff   <= lastsp_in;
      end
   end

endmodule

// File: rtl/aaci_queue.sv
// Small FIFO of work items between the front end and the arithmetic back end.
module aaci_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  aaci_pkg::entry_type  push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 valid,
   output aaci_pkg::entry_type  head
);

   aaci_pkg::entry_type         mem_ff [aaci_pkg::QUEUE_DEPTH];
   logic [aaci_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [aaci_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == aaci_pkg::QCNT_W'(aaci_pkg::QUEUE_DEPTH);
   assign valid = cnt_ff != '0;
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + aaci_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + aaci_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + aaci_pkg::QCNT_W'(push) - aaci_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/aaci_back.sv
// Back end: accumulates argument digits, folds arguments and registers the result.
module aaci_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  aaci_pkg::entry_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [31:0]          rsp_value
);

   aaci_pkg::value_type acc_ff, acc_in, total_ff, total_in;
   aaci_pkg::value_type prod, fold_val, digit_val;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          status_ff, status_in;
   aaci_pkg::value_type value_ff, value_in;
   logic                needs_out;

   assign needs_out = q_head.op == aaci_pkg::OP_LINE || q_head.op == aaci_pkg::OP_OVFL;
   assign q_pop     = q_valid && (!needs_out || !rsp_valid_ff || rsp_ready);
   assign prod      = total_ff * acc_ff;
   assign digit_val = (acc_ff << 3) + (acc_ff << 1)
                      + aaci_pkg::VALUE_WIDTH'(q_head.digit);

   always_comb begin
      if (q_head.first) begin
         fold_val = acc_ff;
      end else begin
         unique case (q_head.cmd)
            aaci_pkg::CMD_ADD: fold_val = total_ff + acc_ff;
            aaci_pkg::CMD_SUB: fold_val = total_ff - acc_ff;
            aaci_pkg::CMD_MUL: fold_val = prod;
            default:           fold_val = total_ff;
         endcase
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      total_in     = total_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (q_pop) begin
         unique case (q_head.op)
            aaci_pkg::OP_DIGIT: acc_in = digit_val;
            aaci_pkg::OP_FOLD: begin
               total_in = fold_val;
               acc_in   = '0;
            end
            aaci_pkg::OP_LINE: begin
               rsp_valid_in = 1'b1;
               status_in    = q_head.status;
               value_in     = (q_head.status == aaci_pkg::ST_OK && q_head.fold)
                              ? fold_val : '0;
               acc_in       = '0;
               total_in     = '0;
            end
            default: begin
               rsp_valid_in = 1'b1;
               status_in    = aaci_pkg::ST_OVERFLOW;
               value_in     = '0;
               acc_in       = '0;
               total_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = 32'(signed'(value_ff));

endmodule

// File: rtl/ascii_arith_command_interpreter.sv
// Top level of the ASCII arithmetic command interpreter.
// Takes one text byte per cycle on req_ and answers each newline-ended line (or a line that
// reaches 256 bytes) with one status/value transaction on rsp_. A byte is taken every cycle
// while the four-entry work queue between the parser and the arithmetic unit has room; the
// arithmetic unit retires one queue entry per cycle while no result waits unaccepted, so
// sustained rate is one byte per clock. A result is offered on rsp_ after its newline passes
// the queue write and then the output register, when no earlier entry waits in the queue.
// While a result waits unaccepted, entries pile up in the queue; req_ready drops once it holds four.
module ascii_arith_command_interpreter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_value
);

   logic                q_full, q_push, q_pop, q_valid;
   aaci_pkg::entry_type q_data, q_head;

   aaci_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_byte_req (req_byte_req),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data)
   );

   aaci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   aaci_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != aaci_pkg::ST_OK |-> rsp_value == '0)
      else $error("nonzero value with error status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= aaci_pkg::ST_OVERFLOW)
      else $error("status code out of range");

endmodule

// File: tb/ascii_arith_command_interpreter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII arithmetic command interpreter, byte stream in, replies out.
module ascii_arith_command_interpreter_tb;

   localparam int QUIET_LIMIT = 5000;
   localparam int ITEM_COUNT  = 1950;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic [2:0]          status;
      aaci_pkg::value_type value;
   } reply_type;

   class interp_scoreboard;
      reply_type           expected_replies[$];
      int                  errors;
      string               cmd_names[4];
      bit                  ignoring, seen_nul, bad_char, empty_arg, last_was_space;
      int                  line_len, word_pos, spaces;
      logic [3:0]          candidates;
      logic [1:0]          cmd;
      aaci_pkg::value_type digits, total;

      function new();
         cmd_names = '{"add", "subtract", "multiply", "bye"};
         errors = 0;
         ignoring = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_len = 0;
         candidates = 4'hF;
         word_pos = 0;
         cmd = aaci_pkg::CMD_ADD;
         seen_nul = 0;
         spaces = 0;
         bad_char = 0;
         empty_arg = 0;
         last_was_space = 0;
         digits = '0;
         total = '0;
      endfunction

      // first word done: only a name of exactly that length survives
      function void resolve_word();
         for (int c = 0; c < 4; c++) begin
            if (cmd_names[c].len() != word_pos) candidates[c] = 1'b0;
            else if (candidates[c]) cmd = 2'(c);
         end
      endfunction

      function void end_arg();
         if (last_was_space) empty_arg = 1;
         if (spaces <= aaci_pkg::MAX_ARGS) begin
            if (spaces == 1) total = digits;
            else case (cmd)
               aaci_pkg::CMD_ADD: total = total + digits;
               aaci_pkg::CMD_SUB: total = total - digits;
               aaci_pkg::CMD_MUL: total = total * digits;
               default: ;
            endcase
         end
      endfunction

      function void push_reply(logic [2:0] st, aaci_pkg::value_type v);
         reply_type r;
         r.status = st;
         r.value = v;
         expected_replies.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [2:0] st;
         if (ignoring) begin
            if (b == aaci_pkg::CH_NL) ignoring = 0;
            return;
         end
         if (b == aaci_pkg::CH_NL) begin
            if (spaces == 0) resolve_word();
            else end_arg();
            if (seen_nul) st = aaci_pkg::ST_BAD_CMD;
            else if (spaces > aaci_pkg::MAX_ARGS) st = aaci_pkg::ST_MANY;
            else if (candidates == 4'd0) st = aaci_pkg::ST_BAD_CMD;
            else if (cmd == aaci_pkg::CMD_BYE) st = aaci_pkg::ST_BYE;
            else if (spaces < 2) st = aaci_pkg::ST_FEW_ARGS;
            else if (bad_char || empty_arg) st = aaci_pkg::ST_BAD_IN;
            else st = aaci_pkg::ST_OK;
            push_reply(st, (st == aaci_pkg::ST_OK) ? total : aaci_pkg::value_type'(0));
            clear_line();
            return;
         end
         line_len++;
         if (b == 8'd0) seen_nul = 1;
         if (b == aaci_pkg::CH_SPACE) begin
            if (spaces == 0) resolve_word();
            else end_arg();
            digits = '0;
            if (spaces <= aaci_pkg::MAX_ARGS) spaces++;
            last_was_space = 1;
         end else begin
            if (spaces == 0) begin
               for (int c = 0; c < 4; c++) begin
                  if (word_pos >= cmd_names[c].len() || cmd_names[c][word_pos] != b)
                     candidates[c] = 1'b0;
               end
               if (word_pos < 15) word_pos++;
            end else if (b >= aaci_pkg::CH_ZERO && b <= aaci_pkg::CH_NINE) begin
               digits = digits * aaci_pkg::value_type'(10)
                        + aaci_pkg::value_type'(b - aaci_pkg::CH_ZERO);
            end else begin
               bad_char = 1;
            end
            last_was_space = 0;
         end
         if (line_len >= aaci_pkg::LINE_CAPACITY) begin
            clear_line();
            ignoring = 1;
            push_reply(aaci_pkg::ST_OVERFLOW, '0);
         end
      endfunction

      function void check_reply(logic [2:0] st, aaci_pkg::value_type v);
         reply_type r;
         if (expected_replies.size() == 0) begin
            errors++;
            $error("unexpected reply: status %0d value %0d", st, $signed(v));
            return;
         end
         r = expected_replies.pop_front();
         if (st !== r.status) begin
            errors++;
            $error("status mismatch: expected %0d, actual %0d", r.status, st);
         end
         if (v !== r.value) begin
            errors++;
            $error("value mismatch: expected %0d, actual %0d", $signed(r.value), $signed(v));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_byte_req = 8'd0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value;

   interp_scoreboard sb;
   logic [7:0]       line_bytes[$];
   string            command_words[4] = '{"add", "subtract", "multiply", "bye"};
   bit               idle_enabled = 1;
   bit               hold_request = 0;
   int               sender_gap_rate = 0;
   int               bytes_sent = 0;
   int               quiet_cycles = 0;

   ascii_arith_command_interpreter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_req(req_byte_req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold on request
   initial begin
      int stall_left;
      int rsp_gap_rate;
      stall_left = 0;
      rsp_gap_rate = 8;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_reply(rsp_status, rsp_value);
         if ($urandom_range(0, 199) == 0) rsp_gap_rate = ($urandom_range(0, 2) == 0) ? 0 : 8;
         if (hold_request) begin
            hold_request = 0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && rsp_gap_rate != 0 &&
                      $urandom_range(1, rsp_gap_rate) == 1) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_char(input logic [7:0] b);
      if (idle_enabled && sender_gap_rate != 0 && $urandom_range(1, sender_gap_rate) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_req <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic flush_line();
      foreach (line_bytes[i]) send_char(line_bytes[i]);
      line_bytes.delete();
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endfunction

   function automatic void add_number();
      int ndig;
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 5);
      repeat (ndig) line_bytes.push_back(aaci_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   task automatic send_text(string s);
      add_text(s);
      line_bytes.push_back(aaci_pkg::CH_NL);
      flush_line();
   endtask

   function automatic logic [7:0] noise_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void build_random_line();
      int kind, c, nargs, pos;
      logic [7:0] b;
      kind = $urandom_range(0, 199);
      if (kind == 0) begin
         // runs past line capacity, tail is dropped
         repeat ($urandom_range(aaci_pkg::LINE_CAPACITY, aaci_pkg::LINE_CAPACITY + 30)) begin
            b = noise_byte();
            line_bytes.push_back((b == aaci_pkg::CH_NL) ? aaci_pkg::CH_SPACE : b);
         end
      end else if (kind < 150) begin
         c = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
         add_text(command_words[c]);
         nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6)
                                              : $urandom_range(2, aaci_pkg::MAX_ARGS);
         repeat (nargs) begin
            line_bytes.push_back(aaci_pkg::CH_SPACE);
            add_number();
         end
         if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, line_bytes.size());
            case ($urandom_range(0, 4))
               0: line_bytes.insert(pos, noise_byte());
               1: line_bytes.insert(pos, aaci_pkg::CH_SPACE);
               2: line_bytes.insert(pos, 8'd0);
               3: line_bytes[0] = line_bytes[0] ^ 8'h20;
               default: line_bytes.push_back(aaci_pkg::CH_SPACE);
            endcase
         end
      end else if (kind < 185) begin
         repeat ($urandom_range(0, 12)) line_bytes.push_back(noise_byte());
      end else begin
         c = $urandom_range(0, 3);
         add_text(command_words[c].substr(0, $urandom_range(0, command_words[c].len() - 1)));
         if ($urandom_range(0, 1) == 0)
            line_bytes.push_back(aaci_pkg::CH_ZERO + 8'($urandom_range(0, 74)));
         repeat ($urandom_range(1, 3)) begin
            line_bytes.push_back(aaci_pkg::CH_SPACE);
            add_number();
         end
      end
      line_bytes.push_back(aaci_pkg::CH_NL);
   endfunction

   initial begin
      bit hold_done, pause_done;
      hold_done = 0;
      pause_done = 0;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_text("add 1 2");
      send_text("subtract 10 3 2");
      send_text("multiply 3 4 5 6");
      send_text("subtract 0 1");
      send_text("add 4294967295 1");
      send_text("multiply 65536 65536");
      send_text("add 99999999999 1");
      send_text("bye");
      send_text("bye 1 2");
      send_text("");
      send_text("add");
      send_text("add 5");
      send_text("add 1 2 3 4 5");
      send_text("Add 1 2");
      send_text("ad 1 2");
      send_text("addd 1 2");
      send_text(" add 1 2");
      send_text("add 1 x");
      send_text("add 1  2");
      send_text("add 1 2 ");
      add_text("add 1");
      line_bytes.push_back(8'd0);
      send_text(" 2");
      add_text("add 1 ");
      line_bytes.push_back(8'hFF);
      send_text("");
      // longest line that still completes
      add_text("add 1 ");
      repeat (aaci_pkg::LINE_CAPACITY - 7) line_bytes.push_back(aaci_pkg::CH_ZERO);
      send_text("");
      // capacity reached, rest of the line dropped
      add_text("multiply 2 ");
      repeat (aaci_pkg::LINE_CAPACITY - 11) line_bytes.push_back(8'hFF);
      send_text(" 3 4");
      send_text("add 7 8");

      while (bytes_sent < ITEM_COUNT) begin
         if (bytes_sent > ITEM_COUNT - 200) idle_enabled = 0;
         case ($urandom_range(0, 2))
            0: sender_gap_rate = 0;
            1: sender_gap_rate = 4;
            default: sender_gap_rate = 16;
         endcase
         if (!hold_done && bytes_sent >= 600) begin
            hold_done = 1;
            hold_request = 1;
            sender_gap_rate = 0;
         end
         if (!pause_done && bytes_sent >= 1200) begin
            pause_done = 1;
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.expected_replies.size() != 0);
         end
         build_random_line();
         flush_line();
      end

      req_valid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
